// ===== hdl/text_escape_stream_converter_core_defines.svh =====
// Assertion macros shared by the text escape converter RTL.
`ifndef TEXT_ESCAPE_STREAM_CONVERTER_CORE_DEFINES_SVH
`define TEXT_ESCAPE_STREAM_CONVERTER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define TESC_ASSERT_NOW(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
// Next-cycle implication.
`define TESC_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define TESC_ASSERT_NOW(label, clk, rst, pre, post, msg)
`define TESC_ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif

`endif

// ===== hdl/tesc_pkg.sv =====
// Types, codes and character constants of the text escape converter.
package tesc_pkg;

   localparam int MAX_TAG_DEPTH = 255;
   localparam int TAG_DEPTH_W   = $clog2(MAX_TAG_DEPTH + 1);
   localparam int MAX_RESULTS   = 3;

   // Mode register codes; the unused code passes bytes unchanged
   localparam logic [2:0] MODE_URL_ESC     = 3'd0;
   localparam logic [2:0] MODE_URL_UNESC   = 3'd1;
   localparam logic [2:0] MODE_PCT_DOUBLE  = 3'd2;
   localparam logic [2:0] MODE_C_ESC       = 3'd3;
   localparam logic [2:0] MODE_C_UNESC     = 3'd4;
   localparam logic [2:0] MODE_C_UNESC_KEEP = 3'd5;
   localparam logic [2:0] MODE_HTML_STRIP  = 3'd6;

   // Escape sequence phases
   localparam logic [1:0] PHASE_IDLE  = 2'd0;
   localparam logic [1:0] PHASE_OPEN  = 2'd1;
   localparam logic [1:0] PHASE_FIRST = 2'd2;

   // Characters
   localparam logic [7:0] CH_NUL     = 8'h00;
   localparam logic [7:0] CH_BS      = 8'h08;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_LF      = 8'h0A;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_DQUOTE  = 8'h22;
   localparam logic [7:0] CH_HASH    = 8'h23;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_SQUOTE  = 8'h27;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_LT      = 8'h3C;
   localparam logic [7:0] CH_GT      = 8'h3E;
   localparam logic [7:0] CH_LBRACK  = 8'h5B;
   localparam logic [7:0] CH_BSLASH  = 8'h5C;
   localparam logic [7:0] CH_RBRACK  = 8'h5D;
   localparam logic [7:0] CH_CARET   = 8'h5E;
   localparam logic [7:0] CH_LOW_B   = 8'h62;
   localparam logic [7:0] CH_LOW_N   = 8'h6E;
   localparam logic [7:0] CH_LOW_R   = 8'h72;
   localparam logic [7:0] CH_LOW_T   = 8'h74;
   localparam logic [7:0] CH_LBRACE  = 8'h7B;
   localparam logic [7:0] CH_PIPE    = 8'h7C;
   localparam logic [7:0] CH_RBRACE  = 8'h7D;
   localparam logic [7:0] CH_TILDE   = 8'h7E;
   localparam logic [7:0] CTRL_LAST  = 8'h1F;
   localparam logic [7:0] DEL_CHAR   = 8'h7F;

   // Pending conversion state
   typedef struct packed {
      logic [1:0]             phase;
      logic [7:0]             first_hex;
      logic [7:0]             last_decoded;
      logic [TAG_DEPTH_W-1:0] tag_depth;
   } conv_state_type;

   // Result group of one item, byte 0 goes out first
   typedef struct packed {
      logic [1:0]      count;
      logic [2:0][7:0] bytes;
   } conv_result_type;

   // Uppercase hex digit of a nibble
   function automatic logic [7:0] hex_digit(input logic [3:0] nib);
      logic [7:0] d;
      if (nib < 4'd10) begin
         d = 8'h30 + {4'd0, nib};
      end else begin
         d = 8'h37 + {4'd0, nib};
      end
      return d;
   endfunction

   // Value of a hex character, bit 4 set when valid
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] v;
      v = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = {1'b1, 4'(c - 8'h37)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         v = {1'b1, 4'(c - 8'h57)};
      end
      return v;
   endfunction

endpackage

// ===== hdl/tesc_convert.sv =====
// Conversion of one byte in the selected mode into up to three result bytes.
module tesc_convert import tesc_pkg::*; (
   input  logic [2:0]      mode,
   input  logic [7:0]      in_byte,
   input  logic            string_end,
   input  conv_state_type  state_cur,
   output conv_state_type  state_next,
   output conv_result_type result
);

   logic [4:0] hi_val;
   logic [4:0] lo_val;
   logic       url_escape;
   logic [7:0] c_letter;

   assign hi_val = hex_value(state_cur.first_hex);
   assign lo_val = hex_value(in_byte);

   // Flag bytes that URL escaping turns into a percent triple
   always_comb begin
      url_escape = (in_byte <= CTRL_LAST) || (in_byte >= DEL_CHAR);
      if (in_byte inside {CH_LT, CH_GT, CH_DQUOTE, CH_HASH, CH_LBRACE, CH_RBRACE, CH_PIPE,
                          CH_BSLASH, CH_CARET, CH_TILDE, CH_LBRACK, CH_RBRACK,
                          CH_SQUOTE}) begin
         url_escape = 1'b1;
      end
   end

   // Letter for C escaping, zero when the byte stays as is
   always_comb begin
      case (in_byte)
         CH_TAB:    c_letter = CH_LOW_T;
         CH_CR:     c_letter = CH_LOW_R;
         CH_LF:     c_letter = CH_LOW_N;
         CH_BS:     c_letter = CH_LOW_B;
         CH_DQUOTE: c_letter = CH_DQUOTE;
         CH_SQUOTE: c_letter = CH_SQUOTE;
         CH_BSLASH: c_letter = CH_BSLASH;
         default:   c_letter = CH_NUL;
      endcase
   end

   // Convert the byte and advance the pending state
   always_comb begin
      conv_state_type st;
      st           = state_cur;
      result.count = 2'd0;
      result.bytes = '0;
      case (mode)
         MODE_URL_ESC: begin
            if (url_escape) begin
               result.count    = 2'd3;
               result.bytes[0] = CH_PERCENT;
               result.bytes[1] = hex_digit(in_byte[7:4]);
               result.bytes[2] = hex_digit(in_byte[3:0]);
            end else begin
               result.count    = 2'd1;
               result.bytes[0] = in_byte;
            end
         end
         MODE_URL_UNESC: begin
            if (state_cur.phase == PHASE_IDLE) begin
               if (in_byte == CH_PERCENT) begin
                  st.phase = PHASE_OPEN;
               end else begin
                  result.count    = 2'd1;
                  result.bytes[0] = in_byte;
               end
            end else if (state_cur.phase == PHASE_OPEN) begin
               st.first_hex = in_byte;
               st.phase     = PHASE_FIRST;
            end else begin
               // Invalid first digit reuses the last decoded value
               if (hi_val[4]) begin
                  st.last_decoded = lo_val[4] ? {hi_val[3:0], lo_val[3:0]}
                                              : {4'd0, hi_val[3:0]};
               end
               result.count    = 2'd1;
               result.bytes[0] = st.last_decoded;
               st.phase        = PHASE_IDLE;
            end
         end
         MODE_PCT_DOUBLE: begin
            result.bytes[0] = in_byte;
            result.bytes[1] = CH_PERCENT;
            result.count    = (in_byte == CH_PERCENT) ? 2'd2 : 2'd1;
         end
         MODE_C_ESC: begin
            if (c_letter != CH_NUL) begin
               result.count    = 2'd2;
               result.bytes[0] = CH_BSLASH;
               result.bytes[1] = c_letter;
            end else begin
               result.count    = 2'd1;
               result.bytes[0] = in_byte;
            end
         end
         MODE_C_UNESC, MODE_C_UNESC_KEEP: begin
            if (state_cur.phase == PHASE_IDLE) begin
               if (in_byte == CH_BSLASH) begin
                  // A lone backslash at string end goes out as is
                  if (string_end) begin
                     result.count    = 2'd1;
                     result.bytes[0] = CH_BSLASH;
                  end else begin
                     st.phase = PHASE_OPEN;
                  end
               end else begin
                  result.count    = 2'd1;
                  result.bytes[0] = in_byte;
               end
            end else begin
               st.phase        = PHASE_IDLE;
               result.count    = 2'd1;
               case (in_byte)
                  CH_LOW_T:  result.bytes[0] = CH_TAB;
                  CH_LOW_R:  result.bytes[0] = CH_CR;
                  CH_LOW_N:  result.bytes[0] = CH_LF;
                  CH_LOW_B:  result.bytes[0] = CH_BS;
                  CH_DQUOTE: result.bytes[0] = CH_DQUOTE;
                  CH_SQUOTE: result.bytes[0] = CH_SQUOTE;
                  CH_ZERO:   result.bytes[0] = CH_NUL;
                  CH_BSLASH: begin
                     result.bytes[0] = CH_BSLASH;
                     result.bytes[1] = CH_BSLASH;
                     result.count    = (mode == MODE_C_UNESC) ? 2'd1 : 2'd2;
                  end
                  default: begin
                     // Unknown escape keeps the backslash
                     result.count    = 2'd2;
                     result.bytes[0] = CH_BSLASH;
                     result.bytes[1] = in_byte;
                  end
               endcase
            end
         end
         MODE_HTML_STRIP: begin
            if (in_byte == CH_LT) begin
               if (state_cur.tag_depth < TAG_DEPTH_W'(MAX_TAG_DEPTH)) begin
                  st.tag_depth = state_cur.tag_depth + 1'b1;
               end
            end else if (in_byte == CH_GT) begin
               if (state_cur.tag_depth != '0) begin
                  st.tag_depth = state_cur.tag_depth - 1'b1;
               end
            end else if (state_cur.tag_depth == '0) begin
               result.count    = 2'd1;
               result.bytes[0] = in_byte;
            end
         end
         default: begin
            result.count    = 2'd1;
            result.bytes[0] = in_byte;
         end
      endcase
      // Drop all pending state after the last byte of a string
      state_next = string_end ? '0 : st;
   end

endmodule

// ===== hdl/tesc_result_buffer.sv =====
// Result register: holds an item's bytes, sends one a cycle unless stalled.
module tesc_result_buffer import tesc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  conv_result_type load_result,
   output logic            can_load,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_run_last
);

   logic [1:0]      remaining_ff;
   logic [1:0]      remaining_in;
   logic [2:0][7:0] slot_ff;
   logic [2:0][7:0] slot_in;
   logic            take;

   assign rsp_valid    = (remaining_ff != 2'd0);
   assign rsp_out_byte = slot_ff[0];
   assign rsp_run_last = (remaining_ff == 2'd1);
   assign take         = rsp_valid && !rsp_stall;
   assign can_load     = !rsp_valid || (rsp_run_last && take);

   // Load a new group or shift the head out
   always_comb begin
      remaining_in = remaining_ff;
      slot_in      = slot_ff;
      if (load) begin
         remaining_in = load_result.count;
         slot_in      = load_result.bytes;
      end else if (take) begin
         remaining_in = remaining_ff - 2'd1;
         slot_in      = {8'h00, slot_ff[2], slot_ff[1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff <= 2'd0;
      end else begin
         remaining_ff <= remaining_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

endmodule

// ===== hdl/text_escape_stream_converter_core.sv =====
// Byte stream converter: URL and C escape and unescape, percent doubling, tag strip.
// An accepted item goes to the input register, its results to the result register.
// Throughput: one item per cycle while rsp_stall is low and each item gives at most
// one byte; else the one-byte result port sends an item's up to 3 bytes one by one.
// Reset: synchronous; mode returns to URL escape and all pending state clears.
// Items that give no result skip the result register and send nothing.
`include "text_escape_stream_converter_core_defines.svh"
module text_escape_stream_converter_core import tesc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_string_end,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [2:0] csr_conversion_mode
);

   logic            in_valid_ff;
   logic            in_valid_in;
   logic [7:0]      in_byte_ff;
   logic            in_last_ff;
   logic [2:0]      mode_ff;
   logic [2:0]      mode_in;
   conv_state_type  state_ff;
   conv_state_type  state_in;
   conv_state_type  state_next;
   conv_result_type result;
   logic            can_load;
   logic            consume;
   logic            buf_load;
   logic            req_take;
   logic            csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // Convert the registered item
   tesc_convert u_convert (
      .mode       (mode_ff),
      .in_byte    (in_byte_ff),
      .string_end (in_last_ff),
      .state_cur  (state_ff),
      .state_next (state_next),
      .result     (result)
   );

   // Hand items with results to the result register, drop empty ones
   assign consume   = in_valid_ff && ((result.count == 2'd0) || can_load);
   assign buf_load  = consume && (result.count != 2'd0);
   assign req_stall = in_valid_ff && !consume;
   assign req_take  = req_valid && !req_stall;

   tesc_result_buffer u_result_buffer (
      .clock        (clock),
      .reset        (reset),
      .load         (buf_load),
      .load_result  (result),
      .can_load     (can_load),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_run_last (rsp_run_last)
   );

   // Input register
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (consume) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_in_byte;
         in_last_ff <= req_string_end;
      end
   end

   // Mode register and pending state; a mode write clears the state
   always_comb begin
      mode_in  = mode_ff;
      state_in = state_ff;
      if (csr_write) begin
         mode_in  = csr_conversion_mode;
         state_in = '0;
      end else if (consume) begin
         state_in = state_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_URL_ESC;
         state_ff <= '0;
      end else begin
         mode_ff  <= mode_in;
         state_ff <= state_in;
      end
   end

   // Checks
   `TESC_ASSERT_NEXT(a_end_clears, clock, reset, consume && in_last_ff, state_ff == '0, "state kept after string end")
   `TESC_ASSERT_NOW(a_depth_strip_only, clock, reset, mode_ff != MODE_HTML_STRIP, state_ff.tag_depth == '0, "tag depth outside strip mode")
   `TESC_ASSERT_NOW(a_c_phase, clock, reset, mode_ff == MODE_C_UNESC || mode_ff == MODE_C_UNESC_KEEP, state_ff.phase != PHASE_FIRST, "hex phase in C unescape")
   `TESC_ASSERT_NOW(a_stall_needs_item, clock, reset, req_stall, in_valid_ff && !consume, "stall without held item")

endmodule

// ===== tb/text_escape_stream_converter_core_tb.sv =====
// Self-checking testbench for the text escape stream converter core.
module text_escape_stream_converter_core_tb import tesc_pkg::*;;

   // Characters and tables used only by the stimulus and the predictor
   localparam logic [2:0] MODE_SPARE = 3'd7;
   localparam logic [7:0] CH_FOUR    = 8'h34;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_UP_A    = 8'h41;
   localparam logic [7:0] CH_UP_F    = 8'h46;
   localparam logic [7:0] CH_LOW_A   = 8'h61;
   localparam logic [7:0] CH_LOW_F   = 8'h66;
   localparam logic [7:0] CH_LOW_G   = 8'h67;
   localparam logic [7:0] CH_LOW_Q   = 8'h71;
   localparam logic [7:0] CH_LOW_X   = 8'h78;
   localparam logic [7:0] CH_LOW_Y   = 8'h79;
   localparam logic [7:0] CH_LOW_Z   = 8'h7A;
   localparam logic [0:15][7:0] HEX_UP  = "0123456789ABCDEF";
   localparam logic [0:21][7:0] HEX_ALL = "0123456789ABCDEFabcdef";
   localparam logic [0:12][7:0] URL_MARKS = {CH_LT, CH_GT, CH_DQUOTE, CH_HASH, CH_LBRACE,
      CH_RBRACE, CH_PIPE, CH_BSLASH, CH_CARET, CH_TILDE, CH_LBRACK, CH_RBRACK, CH_SQUOTE};
   localparam logic [0:6][7:0] C_MARKS = {CH_TAB, CH_CR, CH_LF, CH_BS, CH_DQUOTE, CH_SQUOTE,
      CH_BSLASH};
   localparam logic [0:8][7:0] C_LETTERS = {CH_LOW_T, CH_LOW_R, CH_LOW_N, CH_LOW_B, CH_DQUOTE,
      CH_SQUOTE, CH_ZERO, CH_BSLASH, CH_LOW_Q};
   localparam logic [0:7][2:0] MODE_ORDER = {MODE_URL_ESC, MODE_URL_UNESC, MODE_PCT_DOUBLE,
      MODE_C_ESC, MODE_C_UNESC, MODE_C_UNESC_KEEP, MODE_HTML_STRIP, MODE_SPARE};
   localparam int HOLD_CYCLES = 80;

   typedef struct packed {
      logic [7:0] ch;
      logic       fin;
   } src_char_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } conv_char_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_string_end = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_run_last;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [2:0] csr_conversion_mode = MODE_URL_ESC;

   // Source characters waiting to be sent, converted characters waiting to arrive
   src_char_type   source_chars[$];
   conv_char_type  pending_chars[$];
   logic [7:0]     draft[$];

   int unsigned queued_count = 0;
   int unsigned accepted_count = 0;
   int unsigned error_count = 0;
   int unsigned send_idle_pct = 0;
   int unsigned rcv_idle_pct = 0;
   logic        req_taken = 1'b0;
   logic        rsp_hold = 1'b0;
   logic        hold_go = 1'b0;

   // Converter state as the predictor sees it
   logic [2:0] cur_mode = MODE_URL_ESC;
   logic [1:0] esc_phase = PHASE_IDLE;
   logic [7:0] pct_first = 8'h00;
   logic [7:0] pct_value = 8'h00;
   int         open_tags = 0;

   text_escape_stream_converter_core i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_in_byte         (req_in_byte),
      .req_string_end      (req_string_end),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_run_last        (rsp_run_last),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_conversion_mode (csr_conversion_mode)
   );

   // Clock and reset
   initial begin
      forever #2 clock = ~clock;
   end

   initial begin : watchdog
      #1000000;
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic report_mismatch(input string what);
      $display("%0t mismatch: %s", $time, what);
      error_count++;
   endtask

   function automatic logic needs_pct(input logic [7:0] c);
      logic hit;
      hit = (c <= CTRL_LAST) || (c >= DEL_CHAR);
      case (c)
         CH_LT, CH_GT, CH_DQUOTE, CH_HASH, CH_LBRACE, CH_RBRACE, CH_PIPE,
         CH_BSLASH, CH_CARET, CH_TILDE, CH_LBRACK, CH_RBRACK, CH_SQUOTE: hit = 1'b1;
         default: ;
      endcase
      return hit;
   endfunction

   // Weight of a hex character, -1 when it is none
   function automatic int hex_weight(input logic [7:0] c);
      int w;
      w = -1;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         w = int'(c) - int'(CH_ZERO);
      end else if (c >= CH_UP_A && c <= CH_UP_F) begin
         w = int'(c) - int'(CH_UP_A) + 10;
      end else if (c >= CH_LOW_A && c <= CH_LOW_F) begin
         w = int'(c) - int'(CH_LOW_A) + 10;
      end
      return w;
   endfunction

   function automatic void drop_escape_state();
      esc_phase = PHASE_IDLE;
      pct_first = 8'h00;
      pct_value = 8'h00;
      open_tags = 0;
   endfunction

   // Convert one source character and queue the characters it produces
   task automatic convert_char(input logic [7:0] c, input logic fin);
      logic [7:0] outs[$];
      conv_char_type e;
      int hi;
      int lo;
      case (cur_mode)
         MODE_URL_ESC: begin
            if (needs_pct(c)) begin
               outs.push_back(CH_PERCENT);
               outs.push_back(HEX_UP[c[7:4]]);
               outs.push_back(HEX_UP[c[3:0]]);
            end else begin
               outs.push_back(c);
            end
         end
         MODE_URL_UNESC: begin
            if (esc_phase == PHASE_IDLE) begin
               if (c == CH_PERCENT) begin
                  esc_phase = PHASE_OPEN;
               end else begin
                  outs.push_back(c);
               end
            end else if (esc_phase == PHASE_OPEN) begin
               pct_first = c;
               esc_phase = PHASE_FIRST;
            end else begin
               // an invalid first digit repeats the previous value
               hi = hex_weight(pct_first);
               lo = hex_weight(c);
               if (hi >= 0) begin
                  pct_value = (lo >= 0) ? 8'(hi * 16 + lo) : 8'(hi);
               end
               outs.push_back(pct_value);
               esc_phase = PHASE_IDLE;
            end
         end
         MODE_PCT_DOUBLE: begin
            outs.push_back(c);
            if (c == CH_PERCENT) begin
               outs.push_back(CH_PERCENT);
            end
         end
         MODE_C_ESC: begin
            case (c)
               CH_TAB: begin outs.push_back(CH_BSLASH); outs.push_back(CH_LOW_T); end
               CH_CR: begin outs.push_back(CH_BSLASH); outs.push_back(CH_LOW_R); end
               CH_LF: begin outs.push_back(CH_BSLASH); outs.push_back(CH_LOW_N); end
               CH_BS: begin outs.push_back(CH_BSLASH); outs.push_back(CH_LOW_B); end
               CH_DQUOTE, CH_SQUOTE, CH_BSLASH: begin
                  outs.push_back(CH_BSLASH);
                  outs.push_back(c);
               end
               default: outs.push_back(c);
            endcase
         end
         MODE_C_UNESC, MODE_C_UNESC_KEEP: begin
            if (esc_phase == PHASE_IDLE) begin
               // a backslash that ends the string goes out as is
               if (c != CH_BSLASH) begin
                  outs.push_back(c);
               end else if (fin) begin
                  outs.push_back(CH_BSLASH);
               end else begin
                  esc_phase = PHASE_OPEN;
               end
            end else begin
               esc_phase = PHASE_IDLE;
               case (c)
                  CH_LOW_T: outs.push_back(CH_TAB);
                  CH_LOW_R: outs.push_back(CH_CR);
                  CH_LOW_N: outs.push_back(CH_LF);
                  CH_LOW_B: outs.push_back(CH_BS);
                  CH_DQUOTE, CH_SQUOTE: outs.push_back(c);
                  CH_ZERO: outs.push_back(CH_NUL);
                  CH_BSLASH: begin
                     outs.push_back(CH_BSLASH);
                     if (cur_mode == MODE_C_UNESC_KEEP) begin
                        outs.push_back(CH_BSLASH);
                     end
                  end
                  default: begin
                     outs.push_back(CH_BSLASH);
                     outs.push_back(c);
                  end
               endcase
            end
         end
         MODE_HTML_STRIP: begin
            // saturate the nesting depth at both ends
            if (c == CH_LT) begin
               if (open_tags < MAX_TAG_DEPTH) open_tags++;
            end else if (c == CH_GT) begin
               if (open_tags > 0) open_tags--;
            end else if (open_tags == 0) begin
               outs.push_back(c);
            end
         end
         default: outs.push_back(c);
      endcase
      foreach (outs[i]) begin
         e.ch = outs[i];
         e.last = (i == outs.size() - 1);
         pending_chars.push_back(e);
      end
      if (fin) begin
         drop_escape_state();
      end
   endtask

   // Sample results, mode writes and accepted items at the rising edge
   always @(posedge clock) begin : monitor
      conv_char_type want;
      if (reset) begin
         cur_mode = MODE_URL_ESC;
         drop_escape_state();
         req_taken <= 1'b0;
      end else begin
         if (rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
            if (pending_chars.size() == 0) begin
               report_mismatch($sformatf("unexpected byte %h", rsp_out_byte));
            end else begin
               want = pending_chars.pop_front();
               if (rsp_out_byte !== want.ch) begin
                  report_mismatch($sformatf("out_byte %h, wanted %h", rsp_out_byte, want.ch));
               end
               if (rsp_run_last !== want.last) begin
                  report_mismatch($sformatf("run_last %b, wanted %b on byte %h",
                     rsp_run_last, want.last, want.ch));
               end
            end
         end
         if (csr_valid && csr_ready === 1'b1) begin
            cur_mode = csr_conversion_mode;
            drop_escape_state();
         end
         if (req_valid && req_stall === 1'b0) begin
            convert_char(req_in_byte, req_string_end);
            accepted_count++;
         end
         req_taken <= req_valid && req_stall === 1'b0;
      end
   end

   // Offer the next item once the current one is taken, idling at random
   always @(negedge clock) begin : driver
      src_char_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (source_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = source_chars.pop_front();
            req_valid <= 1'b1;
            req_in_byte <= nxt.ch;
            req_string_end <= nxt.fin;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Stall the result side at random, or hard during a hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= rsp_hold || ($urandom_range(99) < rcv_idle_pct);
      end
   end

   // Block the result side long enough for the converter to back up
   initial begin : rsp_hold_off
      wait (hold_go);
      @(posedge clock);
      rsp_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold = 1'b0;
   end

   task automatic push_char(input logic [7:0] c, input logic fin);
      src_char_type s;
      s.ch = c;
      s.fin = fin;
      source_chars.push_back(s);
      queued_count++;
   endtask

   // Wait until every item is taken and every result is in, then let the core settle
   task automatic wait_drained();
      while (accepted_count != queued_count || pending_chars.size() != 0) begin
         @(negedge clock);
      end
      repeat (6) @(negedge clock);
   endtask

   // Drain, write the mode register, set the idle rates of the next phase
   task automatic begin_phase(input logic [2:0] m, input int unsigned s_pct,
                              input int unsigned r_pct);
      wait_drained();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_conversion_mode <= m;
      do @(posedge clock); while (csr_ready !== 1'b1);
      send_idle_pct = s_pct;
      rcv_idle_pct = r_pct;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [7:0] any_char();
      return 8'($urandom_range(255));
   endfunction

   function automatic logic [7:0] hex_or_noise();
      logic [7:0] c;
      if ($urandom_range(99) < 70) begin
         c = HEX_ALL[$urandom_range(21)];
      end else begin
         c = any_char();
      end
      return c;
   endfunction

   // Append one well-formed token, or noise, suited to the mode
   task automatic add_token(input logic [2:0] m);
      int pick;
      pick = $urandom_range(99);
      case (m)
         MODE_URL_ESC: begin
            if (pick < 20) draft.push_back(URL_MARKS[$urandom_range(12)]);
            else if (pick < 50) draft.push_back(8'($urandom_range(126, 32)));
            else draft.push_back(any_char());
         end
         MODE_URL_UNESC: begin
            if (pick < 40) begin
               draft.push_back(CH_PERCENT);
               draft.push_back(hex_or_noise());
               draft.push_back(hex_or_noise());
            end else begin
               draft.push_back(any_char());
            end
         end
         MODE_PCT_DOUBLE: begin
            draft.push_back(pick < 30 ? CH_PERCENT : any_char());
         end
         MODE_C_ESC: begin
            draft.push_back(pick < 45 ? C_MARKS[$urandom_range(6)] : any_char());
         end
         MODE_C_UNESC, MODE_C_UNESC_KEEP: begin
            if (pick < 45) begin
               draft.push_back(CH_BSLASH);
               if ($urandom_range(99) < 80) draft.push_back(C_LETTERS[$urandom_range(8)]);
               else draft.push_back(any_char());
            end else begin
               draft.push_back(any_char());
            end
         end
         MODE_HTML_STRIP: begin
            if (pick < 25) draft.push_back(CH_LT);
            else if (pick < 50) draft.push_back(CH_GT);
            else draft.push_back(any_char());
         end
         default: draft.push_back(any_char());
      endcase
   endtask

   // Queue random strings of one to ten characters; a cut token is an incomplete escape
   task automatic queue_random(input logic [2:0] m, input int n);
      int added;
      int len;
      added = 0;
      while (added < n) begin
         len = $urandom_range(10, 1);
         draft.delete();
         while (draft.size() < len) add_token(m);
         for (int i = 0; i < len; i++) begin
            push_char(draft[i], i == len - 1);
         end
         added += len;
      end
   endtask

   initial begin : stimulus
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // URL escape: byte extremes
      begin_phase(MODE_URL_ESC, 0, 0);
      push_char(8'h00, 1'b0);
      push_char(8'hFF, 1'b1);

      // URL unescape: bad pair with nothing decoded, one valid digit, cut escape at end
      begin_phase(MODE_URL_UNESC, 0, 0);
      push_char(CH_PERCENT, 1'b0);
      push_char(CH_LOW_Z, 1'b0);
      push_char(CH_LOW_Z, 1'b0);
      push_char(CH_PERCENT, 1'b0);
      push_char(CH_FOUR, 1'b0);
      push_char(CH_LOW_G, 1'b0);
      push_char(CH_PERCENT, 1'b0);
      push_char(CH_LOW_Z, 1'b1);

      begin_phase(MODE_PCT_DOUBLE, 0, 0);
      push_char(CH_PERCENT, 1'b1);

      begin_phase(MODE_C_ESC, 0, 0);
      push_char(CH_TAB, 1'b0);
      push_char(CH_BSLASH, 1'b1);

      // C unescape: doubled backslash, unknown escape, lone backslash at end,
      // then leave a backslash pending across the mode write
      begin_phase(MODE_C_UNESC, 0, 0);
      push_char(CH_BSLASH, 1'b0);
      push_char(CH_BSLASH, 1'b0);
      push_char(CH_BSLASH, 1'b0);
      push_char(CH_LOW_Q, 1'b0);
      push_char(CH_BSLASH, 1'b1);
      push_char(CH_BSLASH, 1'b0);

      begin_phase(MODE_C_UNESC_KEEP, 0, 0);
      push_char(CH_LOW_T, 1'b0);
      push_char(CH_BSLASH, 1'b0);
      push_char(CH_BSLASH, 1'b1);

      // Tag strip: close below depth zero
      begin_phase(MODE_HTML_STRIP, 0, 0);
      push_char(CH_LT, 1'b0);
      push_char(CH_LOW_X, 1'b0);
      push_char(CH_GT, 1'b0);
      push_char(CH_GT, 1'b0);
      push_char(CH_LOW_Y, 1'b1);

      // Random strings in every mode, under three idle patterns
      for (int round = 0; round < 3; round++) begin
         for (int m = 0; m < 8; m++) begin
            case (round)
               0: begin_phase(MODE_ORDER[m], 37, 61);
               1: begin_phase(MODE_ORDER[m], 61, 37);
               default: begin_phase(MODE_ORDER[m], 0, 0);
            endcase
            if (round == 0 && MODE_ORDER[m] == MODE_URL_ESC) begin
               hold_go = 1'b1;
               queue_random(MODE_URL_ESC, 30);
            end else begin
               queue_random(MODE_ORDER[m], 4);
            end
         end
      end

      wait_drained();
      repeat (10) @(negedge clock);
      if (error_count == 0 && pending_chars.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
